@@ design/pli_pkg.sv @@
// Package for the positional list block: beat payload types, opcode and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package pli_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned StW   = 2;
  localparam int unsigned EidxW = 6;
  localparam int unsigned MovW  = 7;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_READ   = 2'd2;

  localparam logic [StW-1:0] ST_OK     = 2'd0;
  localparam logic [StW-1:0] ST_BADPOS = 2'd1;
  localparam logic [StW-1:0] ST_FULL   = 2'd2;
  localparam logic [StW-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic signed [ValW-1:0] element_value;
    logic [EidxW-1:0]       element_index;
    logic [MovW-1:0]        moves;
    logic                   last;
  } out_t;

  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic rotate;    // read-out beat taken, advance the list by one
    logic read_sel;  // output shows the read-out stream
  } ctrl_cmd_t;

  typedef struct packed {
    logic read_go;   // incoming opcode starts a non-empty read-out
    logic last_idx;  // current read-out entry is the final one
  } dp_status_t;

endpackage

@@ design/positional_list_insert_delete.sv @@
// Positional list of signed 32-bit values held in a row of shifting cells.
// An insert or delete moves all later entries in parallel when accepted, then
// its single result beat waits in an output register; the block is ready for
// the next input in the cycle after that beat leaves. A read-out of N entries
// streams N beats, one per cycle while the sink is ready, by rotating the list
// through the head cell. Errors (full list, bad position, empty list, unused
// opcode) give one beat and leave the list unchanged. No clearing pass is
// needed after reset. Depends on pli_pkg, pli_ctrl and pli_datapath.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pli_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pli_pkg::out_t out_data_o
);
  import pli_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pli_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

endmodule

@@ design/pli_ctrl.sv @@
// Controller state machine for the positional list block.
// Depends on pli_pkg for the command and status structs.
module pli_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pli_pkg::dp_status_t status_i,
  output pli_pkg::ctrl_cmd_t  cmd_o
);
  import pli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RESP = 3'b010,
    S_READ = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.read_go ? S_READ : S_RESP;
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        out_valid_o    = 1'b1;
        cmd_o.read_sel = 1'b1;
        if (out_ready_i) begin
          cmd_o.rotate = 1'b1;
          if (status_i.last_idx) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/pli_datapath.sv @@
// Datapath for the positional list block: a row of shifting cells, the entry
// count, the read-out index and the single-beat response register.
// Depends on pli_pkg for payload types, codes and control structs.
module pli_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pli_pkg::in_t        in_data_i,
  input  pli_pkg::ctrl_cmd_t  cmd_i,
  output pli_pkg::dp_status_t status_o,
  output pli_pkg::out_t       out_data_o
);
  import pli_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic signed [ValW-1:0] cell_q [CAPACITY];
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  out_t                   resp_q, resp_d;

  logic [PosW-1:0] cnt_ext;
  logic [PosW-1:0] pos;
  logic            ins_en, del_en, read_go;

  assign cnt_ext = PosW'(count_q);
  assign pos     = in_data_i.position;

  // Decode the incoming beat against the current count.
  always_comb begin
    resp_d        = '0;
    resp_d.last   = 1'b1;
    ins_en        = 1'b0;
    del_en        = 1'b0;
    read_go       = 1'b0;
    unique case (in_data_i.opcode)
      OP_INSERT: begin
        if (count_q == CntW'(CAPACITY)) begin
          resp_d.status = ST_FULL;
        end else if (pos > cnt_ext) begin
          resp_d.status = ST_BADPOS;
        end else begin
          resp_d.status = ST_OK;
          resp_d.moves  = MovW'(cnt_ext - pos);
          ins_en        = 1'b1;
        end
      end
      OP_DELETE: begin
        if (count_q == '0) begin
          resp_d.status = ST_EMPTY;
        end else if (pos >= cnt_ext) begin
          resp_d.status = ST_BADPOS;
        end else begin
          resp_d.status = ST_OK;
          resp_d.moves  = MovW'(cnt_ext - pos - PosW'(1));
          del_en        = 1'b1;
        end
      end
      OP_READ: begin
        if (count_q == '0) begin
          resp_d.status = ST_EMPTY;
        end else begin
          read_go = 1'b1;
        end
      end
      default: begin
        resp_d.status = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.accept) begin
      idx_d = '0;
      if (ins_en) begin
        count_d = count_q + CntW'(1);
      end else if (del_en) begin
        count_d = count_q - CntW'(1);
      end
    end else if (cmd_i.rotate) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      resp_q <= resp_d;
    end
  end

  // Each cell looks only at its neighbors, the head cell and the input value.
  // A read-out rotates the live entries through cell zero and, after one full
  // turn, leaves them where they started.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] up_val, dn_val;
    logic                   above_pos, ins_move, del_move, tail;

    if (i == 0) begin : g_lo
      assign up_val = cell_q[0];
    end else begin : g_mid
      assign up_val = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign dn_val = cell_q[i];
    end else begin : g_top
      assign dn_val = cell_q[i+1];
    end

    assign above_pos = PosW'(i) > pos;
    assign ins_move  = above_pos && (CntW'(i) <= count_q);
    assign del_move  = (PosW'(i) >= pos) && ((CntW'(i) + CntW'(1)) < count_q);
    assign tail      = (CntW'(i) + CntW'(1)) == count_q;

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept && ins_en) begin
        if (PosW'(i) == pos) begin
          cell_q[i] <= in_data_i.value;
        end else if (ins_move) begin
          cell_q[i] <= up_val;
        end
      end else if (cmd_i.accept && del_en) begin
        if (del_move) begin
          cell_q[i] <= dn_val;
        end
      end else if (cmd_i.rotate) begin
        if (tail) begin
          cell_q[i] <= cell_q[0];
        end else if ((CntW'(i) + CntW'(1)) < count_q) begin
          cell_q[i] <= dn_val;
        end
      end
    end
  end

  assign status_o.read_go  = read_go;
  assign status_o.last_idx = (CntW'(idx_q) + CntW'(1)) == count_q;

  always_comb begin
    if (cmd_i.read_sel) begin
      out_data_o.status        = ST_OK;
      out_data_o.element_value = cell_q[0];
      out_data_o.element_index = EidxW'(idx_q);
      out_data_o.moves         = '0;
      out_data_o.last          = status_o.last_idx;
    end else begin
      out_data_o = resp_q;
    end
  end

endmodule
